// ===== sv/rmt_pkg.sv =====
// Shared types for the running median tracker: the per-cell update modes.
package rmt_pkg;

	// Update applied to every cell of one half-store in a cycle.
	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_INSERT,
		MODE_PUSH,
		MODE_POPINS
	} cell_mode_t;

endpackage

// ===== sv/rmt_cell.sv =====
// One sorted-store cell: holds one sample and picks its next value from its neighbors.
module rmt_cell import rmt_pkg::*; #(
	parameter int WIDTH   = 32,
	parameter int CNT_W   = 11,
	parameter int IDX     = 0,
	parameter bit DESCEND = 1'b0
) (
	input  logic                    clk,
	input  cell_mode_t              mode,
	input  logic signed [WIDTH-1:0] sample,
	input  logic [CNT_W-1:0]        size,
	input  logic signed [WIDTH-1:0] prev_val,
	input  logic                    prev_gt,
	input  logic signed [WIDTH-1:0] next_val,
	input  logic                    next_gt,
	output logic signed [WIDTH-1:0] val_q,
	output logic                    gt,
	output logic signed [WIDTH-1:0] nxt
);

	localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

	logic beyond;

	// A cell is past the new sample if it lies farther from the median, or is empty.
	always_comb begin
		if (DESCEND) begin
			beyond = (val_q < sample);
		end else begin
			beyond = (val_q > sample);
		end
		gt = (IdxC >= size) || beyond;
	end

	// Pick the next value: keep, shift outward, shift inward, or take the sample.
	always_comb begin
		unique case (mode)
			MODE_HOLD:   nxt = val_q;
			MODE_INSERT: nxt = prev_gt ? prev_val : (gt ? sample : val_q);
			MODE_PUSH:   nxt = prev_val;
			MODE_POPINS: nxt = gt ? val_q : (next_gt ? sample : next_val);
			default:     nxt = val_q;
		endcase
	end

	// Sample storage.
	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

endmodule

// ===== sv/rmt_chain.sv =====
// One half of the store: a row of cells kept sorted outward from the median.
module rmt_chain import rmt_pkg::*; #(
	parameter int DEPTH   = 512,
	parameter int WIDTH   = 32,
	parameter int CNT_W   = 11,
	parameter bit DESCEND = 1'b0
) (
	input  logic                    clk,
	input  cell_mode_t              mode,
	input  logic signed [WIDTH-1:0] sample,
	input  logic [CNT_W-1:0]        size,
	input  logic signed [WIDTH-1:0] push_val,
	output logic signed [WIDTH-1:0] front_q,
	output logic signed [WIDTH-1:0] front_nxt
);

	logic signed [WIDTH-1:0] val [DEPTH];
	logic signed [WIDTH-1:0] nxt [DEPTH];
	logic                    gt  [DEPTH];

	// Each cell sees its inner and outer neighbor; the innermost cell takes pushed values.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [WIDTH-1:0] p_val;
		logic                    p_gt;
		logic signed [WIDTH-1:0] n_val;
		logic                    n_gt;

		if (i == 0) begin : g_first
			assign p_val = push_val;
			assign p_gt  = 1'b0;
		end else begin : g_inner
			assign p_val = val[i-1];
			assign p_gt  = gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign n_val = val[i];
			assign n_gt  = 1'b1;
		end else begin : g_outer
			assign n_val = val[i+1];
			assign n_gt  = gt[i+1];
		end

		rmt_cell #(
			.WIDTH   (WIDTH),
			.CNT_W   (CNT_W),
			.IDX     (i),
			.DESCEND (DESCEND)
		) u_cell (
			.clk      (clk),
			.mode     (mode),
			.sample   (sample),
			.size     (size),
			.prev_val (p_val),
			.prev_gt  (p_gt),
			.next_val (n_val),
			.next_gt  (n_gt),
			.val_q    (val[i]),
			.gt       (gt[i]),
			.nxt      (nxt[i])
		);
	end

	assign front_q   = val[0];
	assign front_nxt = nxt[0];

endmodule

// ===== sv/running_median_tracker_top.sv =====
// Top level of the running median tracker: control, both half-stores and the result register.
//
// Usage: each request on the input channel (in_valid, in_stall, sample) adds one
// signed sample to the store. Each request produces exactly one result on the
// output channel (out_valid, out_stall): median_twice is twice the median of all
// stored samples, stored_count the number held, dropped_full is set when the
// store already held CAPACITY samples and the sample was discarded.
// The store is two rows of cells: a lower half sorted downward and an upper half
// sorted upward, both from the median. Every cell updates in the same cycle, so
// an insert costs the same however many samples are held, and the median
// always sits in the innermost cell of each row.
// The result is registered and shown in the cycle after the request is taken. Throughput:
// one request per cycle while no result stalls, set by the cell update and result register.
// Reset empties the store (count zero) and clears the result valid; the cells
// and the result payload are not cleared, since nothing reads them until written.
// While a result is held by out_stall, in_stall is raised and no request is taken.
module running_median_tracker_top import rmt_pkg::*; #(
	parameter int CAPACITY    = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_BITS-1:0]        sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_BITS:0]          median_twice,
	output logic [$clog2(CAPACITY+1)-1:0]        stored_count,
	output logic                                 dropped_full
);

	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int L_DEPTH = (CAPACITY + 1) / 2;
	localparam int U_DEPTH = CAPACITY / 2;
	localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

	logic [CNT_W-1:0]              count_q;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS:0]   median_twice_q;
	logic [CNT_W-1:0]              stored_count_q;
	logic                          dropped_full_q;

	logic                          in_fire;
	logic                          full;
	logic [CNT_W:0]                cnt_inc;
	logic [CNT_W-1:0]              lsize;
	logic [CNT_W-1:0]              usize;
	logic [CNT_W-1:0]              count_d;
	cell_mode_t                    l_mode;
	cell_mode_t                    u_mode;
	logic signed [SAMPLE_BITS-1:0] l_front_q;
	logic signed [SAMPLE_BITS-1:0] u_front_q;
	logic signed [SAMPLE_BITS-1:0] l_front_nxt;
	logic signed [SAMPLE_BITS-1:0] u_front_nxt;
	logic signed [SAMPLE_BITS:0]   median_d;

	// Handshake: a request is refused only while a result waits and is stalled.
	assign in_stall = out_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;

	// Half sizes: the lower half holds the extra sample when the count is odd.
	assign full    = (count_q == CapC);
	assign cnt_inc = {1'b0, count_q} + {{CNT_W{1'b0}}, 1'b1};
	assign lsize   = cnt_inc[CNT_W:1];
	assign usize   = count_q >> 1;

	// Decide how each half moves so that both stay balanced around the median.
	always_comb begin
		l_mode  = MODE_HOLD;
		u_mode  = MODE_HOLD;
		count_d = count_q;
		if (in_fire && !full) begin
			count_d = cnt_inc[CNT_W-1:0];
			if (!count_q[0]) begin
				if ((count_q == '0) || (sample <= u_front_q)) begin
					l_mode = MODE_INSERT;
				end else begin
					l_mode = MODE_PUSH;
					u_mode = MODE_POPINS;
				end
			end else begin
				if (sample >= l_front_q) begin
					u_mode = MODE_INSERT;
				end else begin
					u_mode = MODE_PUSH;
					l_mode = MODE_POPINS;
				end
			end
		end
	end

	// Lower half, largest value innermost.
	rmt_chain #(
		.DEPTH   (L_DEPTH),
		.WIDTH   (SAMPLE_BITS),
		.CNT_W   (CNT_W),
		.DESCEND (1'b1)
	) u_lower (
		.clk       (clk),
		.mode      (l_mode),
		.sample    (sample),
		.size      (lsize),
		.push_val  (u_front_q),
		.front_q   (l_front_q),
		.front_nxt (l_front_nxt)
	);

	// Upper half, smallest value innermost.
	rmt_chain #(
		.DEPTH   (U_DEPTH),
		.WIDTH   (SAMPLE_BITS),
		.CNT_W   (CNT_W),
		.DESCEND (1'b0)
	) u_upper (
		.clk       (clk),
		.mode      (u_mode),
		.sample    (sample),
		.size      (usize),
		.push_val  (l_front_q),
		.front_q   (u_front_q),
		.front_nxt (u_front_nxt)
	);

	// Twice the median from the innermost cells after this update.
	always_comb begin
		if (count_d[0]) begin
			median_d = {l_front_nxt, 1'b0};
		end else begin
			median_d = {l_front_nxt[SAMPLE_BITS-1], l_front_nxt}
				+ {u_front_nxt[SAMPLE_BITS-1], u_front_nxt};
		end
	end

	// Sample count and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			median_twice_q <= median_d;
			stored_count_q <= count_d;
			dropped_full_q <= full;
		end
	end

	assign out_valid    = out_valid_q;
	assign median_twice = median_twice_q;
	assign stored_count = stored_count_q;
	assign dropped_full = dropped_full_q;

endmodule

// ===== sv/rmt_checker.sv =====
// Port-level checks for the running median tracker and their bind to the top level.
module rmt_checker #(
	parameter int CAPACITY    = 1024,
	parameter int SAMPLE_BITS = 32
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [SAMPLE_BITS:0]          median_twice,
	input logic [$clog2(CAPACITY+1)-1:0] stored_count,
	input logic                          dropped_full
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

	// Every accepted request shows a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("no result after an accepted request");

	// Input is held back only while a result waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a waiting stalled result");

	// A dropped sample means the store is at capacity.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && dropped_full) |-> (stored_count == CapC))
		else $error("sample dropped while store not full");

	// A stored sample always leaves a nonzero count.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stored_count != '0))
		else $error("result reports an empty store");

	// A stalled result holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(median_twice) && $stable(stored_count)
			&& $stable(dropped_full)))
		else $error("stalled result changed");

endmodule

bind running_median_tracker_top rmt_checker #(
	.CAPACITY    (CAPACITY),
	.SAMPLE_BITS (SAMPLE_BITS)
) u_rmt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.median_twice (median_twice),
	.stored_count (stored_count),
	.dropped_full (dropped_full)
);
